// ===== rtl/bia_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap index allocator package
// Field widths, request codes and reset values shared by the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

  localparam int CNT_W = 11;  // object_count register width
  localparam int IDX_W = 10;  // slot index width

  localparam logic [CNT_W-1:0] COUNT_RESET = 11'd1024;

  // Request codes carried in s_tuser
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

endpackage

`default_nettype wire

// ===== rtl/bitmap_index_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap index allocator
// First-fit slot allocator over an in-use bitmap held in one word-wide memory.
// ----------------------------------------------------------------------------
// An allocate scans the bitmap words from word 0 up to the word of the granted slot, and a
// free scans up to the word of its slot; requests rejected at once (empty range, index
// out of range) skip the scan and go straight to the result state.
// Scan: one word per cycle through the single read port. A request holds the input
// until its result is loaded into the result register, so no new request is taken while
// the result stalls. Reset clears the word-valid flags (all slots free), object_count = 1024.
`default_nettype none

module bitmap_index_allocator #(
  parameter int CAPACITY  = 1024,
  parameter int WORD_BITS = 32
) (
  input  wire  logic                                clk,
  input  wire  logic                                rst,
  // configuration: object_count
  input  wire  logic                                cfg_we,
  input  wire  logic [bia_pkg::CNT_W-1:0]           cfg_wdata,
  // requests
  input  wire  logic                                s_tvalid,
  output logic                                      s_tready,
  input  wire  logic [bia_pkg::IN_TDATA_W-1:0]      s_tdata,   // [9:0] slot_index
  input  wire  logic [0:0]                          s_tuser,   // [0] action
  // results
  output logic                                      m_tvalid,
  input  wire  logic                                m_tready,
  output logic [bia_pkg::OUT_TDATA_W-1:0]           m_tdata    // [0] ok, [10:1] granted_index
);

  localparam int CNT_W = bia_pkg::CNT_W;
  localparam int IDX_W = bia_pkg::IDX_W;
  // object_count can never reach past this, so words beyond are never touched
  localparam int CNT_MAX    = (1 << CNT_W) - 1;
  localparam int LIMIT_MAX  = (CAPACITY < CNT_MAX) ? CAPACITY : CNT_MAX;
  localparam int USED_WORDS = (LIMIT_MAX + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
  localparam int OW = $clog2(WORD_BITS);
  localparam int BW = $clog2(USED_WORDS * WORD_BITS + 1);
  localparam int XW = ((BW > CNT_W) ? BW : CNT_W) + 1;
  localparam int GW = (BW > IDX_W) ? BW : IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]           state;
  logic [CNT_W-1:0]     object_count;
  logic                 op;
  logic [IDX_W-1:0]     slot;
  logic [AW-1:0]        word_addr;
  logic [BW-1:0]        base;
  logic                 res_ok;
  logic [IDX_W-1:0]     res_idx;
  logic                 out_ok;
  logic [IDX_W-1:0]     out_idx;

  logic [WORD_BITS-1:0] mem [USED_WORDS];
  logic [USED_WORDS-1:0] vld;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_valid;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [CNT_W-1:0]     limit;
  logic [WORD_BITS-1:0] word_val;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] avail;
  logic [XW-1:0]        remain;
  logic [XW-1:0]        base_end;
  logic                 more;
  logic                 found;
  logic [OW-1:0]        hit;
  logic [OW-1:0]        bit_off;
  logic [XW-1:0]        slot_off;
  logic [GW-1:0]        grant_full;
  logic                 s_accept;
  logic                 out_free;

  assign limit    = (32'(object_count) > CAPACITY) ? CNT_W'(CAPACITY) : object_count;
  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{(bia_pkg::OUT_TDATA_W - IDX_W - 1){1'b0}}, out_idx, out_ok};

  // Current word as seen by the scan; a word never written reads as all free.
  assign word_val = rd_valid ? rd_data : '0;
  assign remain   = XW'(limit) - XW'(base);
  assign base_end = XW'(base) + XW'(WORD_BITS);
  assign more     = base_end < XW'(limit);
  assign slot_off = XW'(slot) - XW'(base);
  assign bit_off  = slot_off[OW-1:0];

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mask[j] = XW'(j) < remain;
    end
    avail = ~word_val & mask;
  end

  // Lowest free slot within the word.
  always_comb begin
    found = 1'b0;
    hit   = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        found = 1'b1;
        hit   = OW'(j);
      end
    end
  end

  assign grant_full = GW'(base) + GW'(hit);

  // While scanning, the next word is read ahead so one word is examined per cycle.
  always_comb begin
    rd_addr   = '0;
    mem_we    = 1'b0;
    mem_wdata = word_val;
    if (state == S_EVAL) begin
      rd_addr = more ? (word_addr + AW'(1)) : word_addr;
      if (op == bia_pkg::ACT_ALLOC) begin
        if (found) begin
          mem_we    = 1'b1;
          mem_wdata = word_val | (WORD_BITS'(1) << hit);
        end
      end else if (XW'(slot) < base_end) begin
        mem_we    = 1'b1;
        mem_wdata = word_val & ~(WORD_BITS'(1) << bit_off);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_addr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (mem_we) begin
        vld[word_addr] <= 1'b1;
      end
      rd_valid <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      object_count <= bia_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      object_count <= cfg_wdata;
    end
  end

  // Result register: loaded from the finished request, cleared by its transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_accept) begin
            op        <= s_tuser[0];
            slot      <= s_tdata[IDX_W-1:0];
            word_addr <= '0;
            base      <= '0;
            res_ok    <= 1'b0;
            res_idx   <= '0;
            if (s_tuser[0] == bia_pkg::ACT_ALLOC) begin
              state <= (limit == '0) ? S_DONE : S_EVAL;
            end else begin
              state <= (CNT_W'(s_tdata[IDX_W-1:0]) < limit) ? S_EVAL : S_DONE;
            end
          end
        end
        S_EVAL: begin
          if (op == bia_pkg::ACT_ALLOC) begin
            if (found) begin
              res_ok  <= 1'b1;
              res_idx <= grant_full[IDX_W-1:0];
              state   <= S_DONE;
            end else if (more) begin
              word_addr <= word_addr + AW'(1);
              base      <= base + BW'(WORD_BITS);
            end else begin
              state <= S_DONE;
            end
          end else if (XW'(slot) < base_end) begin
            res_ok <= word_val[bit_off];
            state  <= S_DONE;
          end else begin
            word_addr <= word_addr + AW'(1);
            base      <= base + BW'(WORD_BITS);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_ok   <= res_ok;
            out_idx  <= res_idx;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The scan never looks at a word that starts at or past the slot limit.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (XW'(base) < XW'(limit)))
    else $error("scan reached a word beyond the slot limit");

  // A free only ever runs while its slot lies below the limit.
  a_free_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && op == bia_pkg::ACT_FREE) |-> (CNT_W'(slot) < limit))
    else $error("free scan started for an out-of-range slot");

  // A result is only presented after the request has been finished.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result presented without a finished request");

  // An accepted request enters the scan or completes at once, never idles.
  a_accept_moves: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == S_EVAL || state == S_DONE))
    else $error("accepted request was dropped");

  // The bitmap is written only from the evaluate step.
  a_write_in_eval: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_EVAL && word_addr == rd_addr - AW'(more)))
    else $error("bitmap written outside the evaluate step");

endmodule

`default_nettype wire

// ===== sim/bitmap_index_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap index allocator testbench
// Drives allocate and free requests through the request stream under random
// bursts and gaps, while the result stream stalls on its own schedule. A
// built-in slot map predicts every result, and each result is checked field
// by field. object_count is rewritten between phases, its extremes included.
// ----------------------------------------------------------------------------
module bitmap_index_allocator_test;

  localparam int CAPACITY     = 1024;
  localparam int WORD_BITS    = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = CAPACITY / WORD_BITS + 8;
  localparam int IDX_W        = bia_pkg::IDX_W;
  localparam int CNT_W        = bia_pkg::CNT_W;
  localparam int IN_TDATA_W   = bia_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W  = bia_pkg::OUT_TDATA_W;

  typedef struct {
    logic             act;
    logic [IDX_W-1:0] idx;
    logic             ok;
    logic [IDX_W-1:0] granted;
  } slot_reply_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CNT_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // [9:0] slot_index
  logic [0:0]             s_tuser   = '0;   // [0] action
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;          // [0] ok, [10:1] granted_index

  // Predicted state of the allocator.
  bit               slot_used [CAPACITY];
  logic [CNT_W-1:0] count_reg = bia_pkg::COUNT_RESET;
  slot_reply_t      pending_replies[$];

  int mismatches      = 0;
  int replies_checked = 0;
  int grants          = 0;
  int alloc_failures  = 0;
  int release_hits    = 0;
  int release_misses  = 0;
  int count_writes    = 0;
  int burst_left      = 0;
  int cycles          = 0;
  int stall_mode      = 0;
  int stall_left      = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  bitmap_index_allocator #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  function automatic int slot_limit();
    return (count_reg > CAPACITY) ? CAPACITY : int'(count_reg);
  endfunction

  // First fit for allocate; clear and report the old bit for free.
  function automatic slot_reply_t allocate_or_release(input logic act,
                                                      input logic [IDX_W-1:0] idx);
    slot_reply_t r;
    int          lim;
    bit          found;
    lim       = slot_limit();
    found     = 1'b0;
    r.act     = act;
    r.idx     = idx;
    r.ok      = 1'b0;
    r.granted = '0;
    if (act == bia_pkg::ACT_ALLOC) begin
      for (int i = 0; i < lim; i++) begin
        if (!found && !slot_used[i]) begin
          found        = 1'b1;
          slot_used[i] = 1'b1;
          r.ok         = 1'b1;
          r.granted    = IDX_W'(i);
        end
      end
    end else if (int'(idx) < lim) begin
      r.ok           = slot_used[idx];
      slot_used[idx] = 1'b0;
    end
    return r;
  endfunction

  // Presents one request, waits for its transaction and records the prediction.
  // Valid stays high into the next request unless the burst has run out.
  task automatic send_request(input logic act, input logic [IDX_W-1:0] idx);
    slot_reply_t r;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{(IN_TDATA_W-IDX_W){1'b0}}, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = allocate_or_release(act, idx);
    pending_replies.push_back(r);
    if (act == bia_pkg::ACT_ALLOC) begin
      if (r.ok) grants++;
      else alloc_failures++;
    end else begin
      if (r.ok) release_hits++;
      else release_misses++;
    end
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_idle();
    if (s_tvalid) s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_object_count(input logic [CNT_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_reg = value;
    count_writes++;
  endtask

  task automatic flag_mismatch(input string what, input slot_reply_t want,
                               input logic got_ok, input logic [IDX_W-1:0] got_idx);
    mismatches++;
    if (mismatches <= 10)
      $display("MISMATCH %s: action %0d slot %0d, expected ok %0d index %0d, %s",
               what, want.act, want.idx, want.ok, want.granted,
               $sformatf("got ok %0d index %0d", got_ok, got_idx));
  endtask

  task automatic check_reply();
    slot_reply_t      want;
    logic             got_ok;
    logic [IDX_W-1:0] got_idx;
    got_ok  = m_tdata[0];
    got_idx = m_tdata[IDX_W:1];
    replies_checked++;
    if (pending_replies.size() == 0) begin
      want = '{act: 1'b0, idx: '0, ok: 1'b0, granted: '0};
      flag_mismatch("result with nothing pending", want, got_ok, got_idx);
    end else begin
      want = pending_replies.pop_front();
      if (got_ok !== want.ok) flag_mismatch("ok", want, got_ok, got_idx);
      if (got_idx !== want.granted) flag_mismatch("granted_index", want, got_ok, got_idx);
    end
  endtask

  // Result side: check each transaction, and change the stall behavior from
  // time to time between always ready, light stalls and heavy stalls.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_reply();
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 100);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= ($urandom_range(0, 2) != 0);
        end
        default: begin
          m_tready <= ($urandom_range(0, 5) == 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results pending.", cycles,
               pending_replies.size());
      $display("bitmap_index_allocator_test: errors");
      $finish;
    end
  end

  // Extremes of the count, a full range, double free and a lowered count.
  task automatic test_directed_cases();
    send_request(bia_pkg::ACT_ALLOC, '0);
    send_request(bia_pkg::ACT_ALLOC, '0);
    send_request(bia_pkg::ACT_ALLOC, '0);
    send_request(bia_pkg::ACT_FREE, 10'd1);
    send_request(bia_pkg::ACT_FREE, 10'd1);
    send_request(bia_pkg::ACT_FREE, 10'd1023);
    send_request(bia_pkg::ACT_ALLOC, 10'd1023);
    set_object_count(11'd0);
    send_request(bia_pkg::ACT_ALLOC, '0);
    send_request(bia_pkg::ACT_FREE, 10'd0);
    set_object_count(11'd2047);
    send_request(bia_pkg::ACT_ALLOC, 10'd682);
    send_request(bia_pkg::ACT_FREE, 10'd1023);
    set_object_count(11'd3);
    send_request(bia_pkg::ACT_ALLOC, '0);
    // Slot 2 stays in use but lies beyond the lowered count.
    set_object_count(11'd2);
    send_request(bia_pkg::ACT_FREE, 10'd2);
    send_request(bia_pkg::ACT_FREE, 10'd1);
    send_request(bia_pkg::ACT_ALLOC, 10'd341);
    set_object_count(11'd1);
    send_request(bia_pkg::ACT_FREE, 10'd0);
    send_request(bia_pkg::ACT_ALLOC, '0);
    send_request(bia_pkg::ACT_ALLOC, '0);
    set_object_count(11'd33);
    send_request(bia_pkg::ACT_FREE, 10'd3);
    send_request(bia_pkg::ACT_ALLOC, '0);
    send_request(bia_pkg::ACT_FREE, 10'd32);
    send_request(bia_pkg::ACT_FREE, 10'd33);
    send_request(bia_pkg::ACT_FREE, 10'd512);
  endtask

  // Phases with a fresh count each, mixing allocates and frees so that the
  // range fills up and drains again.
  task automatic test_random_churn(input int total);
    int done;
    int n;
    int alloc_pct;
    int lim;
    int pick;
    logic [IDX_W-1:0] idx;
    done = 0;
    while (done < total) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: set_object_count(11'd0);
        1: set_object_count(11'd2047);
        2: set_object_count(11'd1024);
        3: set_object_count(CNT_W'($urandom_range(1025, 2046)));
        4, 5: set_object_count(CNT_W'($urandom_range(1, 16)));
        6, 7: set_object_count(CNT_W'($urandom_range(17, 80)));
        8: set_object_count(CNT_W'(32 * $urandom_range(1, 4)));
        default: set_object_count(CNT_W'($urandom_range(81, 300)));
      endcase
      lim       = slot_limit();
      alloc_pct = $urandom_range(25, 75);
      n         = $urandom_range(20, 60);
      if (n > total - done) n = total - done;
      repeat (n) begin
        idx = IDX_W'($urandom_range(0, CAPACITY - 1));
        if ($urandom_range(0, 99) < alloc_pct) begin
          send_request(bia_pkg::ACT_ALLOC, idx);
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70 && lim > 0) idx = IDX_W'($urandom_range(0, lim - 1));
          else if (pick >= 85 && lim < CAPACITY)
            idx = IDX_W'($urandom_range(lim, (lim + 3 < CAPACITY) ? lim + 3 : CAPACITY - 1));
          send_request(bia_pkg::ACT_FREE, idx);
        end
        done++;
      end
    end
  endtask

  // Full range: enough allocations to push the first free slot several
  // words up, with the odd release in between, and the top slots released.
  task automatic test_deep_scan();
    int top;
    set_object_count(11'd1024);
    top = 0;
    repeat (150) begin
      if ($urandom_range(0, 7) == 0 && top > 0) begin
        send_request(bia_pkg::ACT_FREE, IDX_W'($urandom_range(0, top)));
      end else begin
        send_request(bia_pkg::ACT_ALLOC, IDX_W'($urandom_range(0, CAPACITY - 1)));
        top++;
      end
    end
    send_request(bia_pkg::ACT_FREE, 10'd1000);
    send_request(bia_pkg::ACT_FREE, 10'd1023);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_random_churn(300);
    test_deep_scan();
    test_random_churn(180);
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d grants, %0d failed allocates, %0d releases of used slots",
             grants, alloc_failures, release_hits);
    $display("and %0d empty releases over %0d object_count settings; %0d results checked.",
             release_misses, count_writes, replies_checked);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("bitmap_index_allocator_test: clean");
    end else begin
      $display("bitmap_index_allocator_test: errors");
    end
    $finish;
  end

endmodule
